@@ hdl/asbd_pkg.sv @@
// Shared types and constants of the battery measurement scheduler.
package asbd_pkg;

	// Fixed field widths.
	localparam int KIND_W      = 2;
	localparam int PHASE_W     = 2;
	localparam int REG_W       = 16;
	localparam int LEVEL_W     = 23;
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 23;

	// The divider produces one quotient bit per step.
	localparam int DIV_STEPS = LEVEL_W;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	// Configuration register indexes.
	localparam logic [CFG_INDEX_W-1:0] CFG_SLOW_PERIOD  = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_FAST_PERIOD  = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_FAST_WINDOW  = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] CFG_STARTUP_LEAD = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] CFG_RATIO_NUM    = 3'd4;

	// Reset values of the configuration registers.
	localparam logic [REG_W-1:0]   SLOW_PERIOD_RST  = 16'd36000;
	localparam logic [REG_W-1:0]   FAST_PERIOD_RST  = 16'd60;
	localparam logic [REG_W-1:0]   FAST_WINDOW_RST  = 16'd2400;
	localparam logic [REG_W-1:0]   STARTUP_LEAD_RST = 16'd40;
	localparam logic [LEVEL_W-1:0] RATIO_NUM_RST    = 23'd4997120;

	// Item kinds.
	typedef enum logic [KIND_W-1:0] {
		KIND_TICK    = 2'd0,
		KIND_TRIGGER = 2'd1,
		KIND_TRESET  = 2'd2,
		KIND_INIT    = 2'd3
	} kind_t;

	// Measurement sequencer phases.
	typedef enum logic [PHASE_W-1:0] {
		PH_IDLE    = 2'd0,
		PH_READY   = 2'd1,
		PH_COLLECT = 2'd2,
		PH_FINISH  = 2'd3
	} phase_t;

	// Configuration register set.
	typedef struct packed {
		logic [REG_W-1:0]   slow_period;
		logic [REG_W-1:0]   fast_period;
		logic [REG_W-1:0]   fast_window;
		logic [REG_W-1:0]   startup_lead;
		logic [LEVEL_W-1:0] ratio_numerator;
	} cfg_regs_t;

	// One result item.
	typedef struct packed {
		phase_t             phase;
		logic               adc_open;
		logic               adc_close;
		logic               collect_flag;
		logic [LEVEL_W-1:0] battery_level;
		logic               level_valid;
		logic               divide_error;
		logic               fast_mode;
	} result_t;

endpackage

@@ hdl/asbd_in_if.sv @@
// Input item channel of the battery measurement scheduler.
interface asbd_in_if #(
	parameter int SAMPLE_WIDTH = 12
) ();
	logic                           valid;
	logic                           ready;
	logic [asbd_pkg::KIND_W-1:0]    kind;
	logic                           key_request;
	logic [SAMPLE_WIDTH-1:0]        adc_sample;

	modport source (output valid, kind, key_request, adc_sample, input ready);
	modport sink   (input valid, kind, key_request, adc_sample, output ready);
endinterface

@@ hdl/asbd_out_if.sv @@
// Result channel of the battery measurement scheduler.
interface asbd_out_if ();
	logic                           valid;
	logic                           ready;
	logic [asbd_pkg::PHASE_W-1:0]   phase;
	logic                           adc_open;
	logic                           adc_close;
	logic                           collect_flag;
	logic [asbd_pkg::LEVEL_W-1:0]   battery_level;
	logic                           level_valid;
	logic                           divide_error;
	logic                           fast_mode;

	modport source (output valid, phase, adc_open, adc_close, collect_flag, battery_level,
		level_valid, divide_error, fast_mode, input ready);
	modport sink   (input valid, phase, adc_open, adc_close, collect_flag, battery_level,
		level_valid, divide_error, fast_mode, output ready);
endinterface

@@ hdl/asbd_cfg_if.sv @@
// Configuration write channel of the battery measurement scheduler.
interface asbd_cfg_if ();
	logic                              valid;
	logic                              ready;
	logic [asbd_pkg::CFG_INDEX_W-1:0]  index;
	logic [asbd_pkg::CFG_DATA_W-1:0]   data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

@@ hdl/asbd_div.sv @@
// Bit-serial restoring divider: one quotient bit per cycle.
module asbd_div #(
	parameter int SAMPLE_WIDTH = 12
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [asbd_pkg::LEVEL_W-1:0] dividend,
	input  logic [SAMPLE_WIDTH-1:0]      divisor,
	output logic                         done,
	output logic [asbd_pkg::LEVEL_W-1:0] quotient
);
	logic                           busy_q;
	logic                           done_q;
	logic [asbd_pkg::DIV_CNT_W-1:0] cnt_q;
	logic [SAMPLE_WIDTH-1:0]        rem_q;
	logic [SAMPLE_WIDTH-1:0]        divisor_q;
	logic [asbd_pkg::LEVEL_W-1:0]   quo_q;
	logic [SAMPLE_WIDTH:0]          shifted;
	logic [SAMPLE_WIDTH:0]          diff;
	logic                           ge;

	// One restoring step: bring in the next dividend bit and try a subtract.
	always_comb begin
		shifted = {rem_q, quo_q[asbd_pkg::LEVEL_W-1]};
		diff    = shifted - {1'b0, divisor_q};
		ge      = (shifted >= {1'b0, divisor_q});
	end

	// Step control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= asbd_pkg::DIV_CNT_W'(asbd_pkg::DIV_STEPS - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - asbd_pkg::DIV_CNT_W'(1);
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: the dividend shifts out at the top while quotient bits enter below.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q     <= '0;
			divisor_q <= divisor;
			quo_q     <= dividend;
		end else if (busy_q) begin
			rem_q <= ge ? diff[SAMPLE_WIDTH-1:0] : shifted[SAMPLE_WIDTH-1:0];
			quo_q <= {quo_q[asbd_pkg::LEVEL_W-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;
endmodule

@@ hdl/asbd_sched.sv @@
// Measurement schedule state and the per-item update of the sequencer.
module asbd_sched #(
	parameter int COUNT_WIDTH  = 16,
	parameter int SAMPLE_WIDTH = 12
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         commit,
	input  asbd_pkg::kind_t              kind,
	input  logic                         key_request,
	input  logic [SAMPLE_WIDTH-1:0]      adc_sample,
	input  asbd_pkg::cfg_regs_t          regs,
	input  logic [asbd_pkg::LEVEL_W-1:0] quotient,
	output logic                         need_div,
	output asbd_pkg::result_t            result
);
	localparam int CMP_W = ((COUNT_WIDTH > asbd_pkg::REG_W) ? COUNT_WIDTH : asbd_pkg::REG_W) + 1;

	asbd_pkg::phase_t             phase_q, phase_d;
	logic [COUNT_WIDTH-1:0]       slow_count_q, slow_count_d;
	logic [COUNT_WIDTH-1:0]       window_count_q, window_count_d;
	logic [COUNT_WIDTH-1:0]       fast_count_q, fast_count_d;
	logic                         fast_flag_q, fast_flag_d;
	logic                         collecting_q, collecting_d;
	logic [asbd_pkg::LEVEL_W-1:0] level_q, level_d;
	logic                         opened, closed, lvl_valid, err;
	logic [CMP_W-1:0]             snext, wnext, fnext;

	assign need_div = (kind == asbd_pkg::KIND_TICK) && (phase_q == asbd_pkg::PH_COLLECT);

	// Incremented counters, one bit wider than any operand so they never wrap.
	always_comb begin
		snext = CMP_W'(slow_count_q) + CMP_W'(1);
		wnext = CMP_W'(window_count_q) + CMP_W'(1);
		fnext = CMP_W'(fast_count_q) + CMP_W'(1);
	end

	// Next state for the item in hand.
	always_comb begin
		phase_d        = phase_q;
		slow_count_d   = slow_count_q;
		window_count_d = window_count_q;
		fast_count_d   = fast_count_q;
		fast_flag_d    = fast_flag_q | key_request;
		collecting_d   = collecting_q;
		level_d        = level_q;
		opened         = 1'b0;
		closed         = 1'b0;
		lvl_valid      = 1'b0;
		err            = 1'b0;
		unique case (kind)
			asbd_pkg::KIND_TICK: begin
				unique case (phase_q)
					asbd_pkg::PH_IDLE: begin
						if (fast_flag_d) begin
							if (wnext <= CMP_W'(regs.fast_window)) begin
								window_count_d = wnext[COUNT_WIDTH-1:0];
								if (fnext >= CMP_W'(regs.fast_period)) begin
									phase_d      = asbd_pkg::PH_READY;
									fast_count_d = '0;
								end else begin
									fast_count_d = fnext[COUNT_WIDTH-1:0];
								end
							end else begin
								// Fast window ran out: back to slow mode.
								fast_flag_d    = 1'b0;
								window_count_d = '0;
							end
						end else if (snext >= CMP_W'(regs.slow_period)) begin
							phase_d      = asbd_pkg::PH_READY;
							slow_count_d = '0;
						end else begin
							slow_count_d = snext[COUNT_WIDTH-1:0];
						end
					end
					asbd_pkg::PH_READY: begin
						opened       = 1'b1;
						collecting_d = 1'b1;
						phase_d      = asbd_pkg::PH_COLLECT;
					end
					asbd_pkg::PH_COLLECT: begin
						// A zero sample saturates the level to the numerator.
						if (adc_sample == '0) begin
							level_d = regs.ratio_numerator;
							err     = 1'b1;
						end else begin
							level_d = quotient;
						end
						lvl_valid    = 1'b1;
						collecting_d = 1'b0;
						phase_d      = asbd_pkg::PH_FINISH;
					end
					default: begin
						closed  = 1'b1;
						phase_d = asbd_pkg::PH_IDLE;
					end
				endcase
			end
			asbd_pkg::KIND_TRIGGER: begin
				phase_d = asbd_pkg::PH_READY;
			end
			asbd_pkg::KIND_TRESET: begin
				slow_count_d   = '0;
				window_count_d = '0;
				fast_count_d   = (regs.fast_period == '0) ? '0 :
					COUNT_WIDTH'(regs.fast_period - asbd_pkg::REG_W'(1));
			end
			default: begin
				slow_count_d = (regs.startup_lead >= regs.slow_period) ? '0 :
					COUNT_WIDTH'(regs.slow_period - regs.startup_lead);
			end
		endcase
	end

	// Result of the item, showing the state after it.
	always_comb begin
		result.phase         = phase_d;
		result.adc_open      = opened;
		result.adc_close     = closed;
		result.collect_flag  = collecting_d;
		result.battery_level = level_d;
		result.level_valid   = lvl_valid;
		result.divide_error  = err;
		result.fast_mode     = fast_flag_d;
	end

	// Schedule state updates once the item's result is committed.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= asbd_pkg::PH_IDLE;
			slow_count_q   <= '0;
			window_count_q <= '0;
			fast_count_q   <= '0;
			fast_flag_q    <= 1'b0;
			collecting_q   <= 1'b0;
			level_q        <= '0;
		end else if (commit) begin
			phase_q        <= phase_d;
			slow_count_q   <= slow_count_d;
			window_count_q <= window_count_d;
			fast_count_q   <= fast_count_d;
			fast_flag_q    <= fast_flag_d;
			collecting_q   <= collecting_d;
			level_q        <= level_d;
		end
	end
endmodule

@@ hdl/adc_sample_scheduler_battery_divider_top.sv @@
// Top level of the battery measurement scheduler with bit-serial level divider.
//
// Items (tick, trigger, timer reset, init) arrive on in_ch; each produces exactly
// one result on out_ch. Configuration registers are written on cfg (index 0 slow
// period, 1 fast period, 2 fast window, 3 startup lead, 4 ratio numerator); cfg is
// always ready and writes to other indexes are dropped. Write them only while idle.
// One item is handled at a time. An item that does not collect a sample is captured,
// then its result is committed into the output register once that register is free,
// and in_ch is ready again from then on. A tick in the collect phase runs the
// 23-step bit-serial divider, one quotient bit per cycle, before its result is committed.
// The result sits in an output register, so the next input transfer is taken while
// a result still waits on out_ch; if the receiver stalls, the following result is
// held inside and in_ch stays not ready until the output register frees up.
// Reset clears the schedule state and loads the default configuration; no result
// is pending afterward.
module adc_sample_scheduler_battery_divider_top #(
	parameter int COUNT_WIDTH  = 16,
	parameter int SAMPLE_WIDTH = 12
) (
	input logic          clk,
	input logic          arst_n,
	asbd_in_if.sink      in_ch,
	asbd_out_if.source   out_ch,
	asbd_cfg_if.sink     cfg
);
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PREP,
		ST_DIV,
		ST_HOLD
	} state_t;

	state_t                       state_q;
	asbd_pkg::cfg_regs_t          regs_q;
	asbd_pkg::kind_t              kind_q;
	logic                         key_q;
	logic [SAMPLE_WIDTH-1:0]      sample_q;
	logic                         out_valid_q;
	asbd_pkg::result_t            out_q;
	asbd_pkg::result_t            result;
	logic                         need_div;
	logic                         div_start;
	logic                         div_done;
	logic [asbd_pkg::LEVEL_W-1:0] quotient;
	logic                         slot_free;
	logic                         commit;

	// Configuration registers.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.slow_period     <= asbd_pkg::SLOW_PERIOD_RST;
			regs_q.fast_period     <= asbd_pkg::FAST_PERIOD_RST;
			regs_q.fast_window     <= asbd_pkg::FAST_WINDOW_RST;
			regs_q.startup_lead    <= asbd_pkg::STARTUP_LEAD_RST;
			regs_q.ratio_numerator <= asbd_pkg::RATIO_NUM_RST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				asbd_pkg::CFG_SLOW_PERIOD:  regs_q.slow_period  <= cfg.data[asbd_pkg::REG_W-1:0];
				asbd_pkg::CFG_FAST_PERIOD:  regs_q.fast_period  <= cfg.data[asbd_pkg::REG_W-1:0];
				asbd_pkg::CFG_FAST_WINDOW:  regs_q.fast_window  <= cfg.data[asbd_pkg::REG_W-1:0];
				asbd_pkg::CFG_STARTUP_LEAD: regs_q.startup_lead <= cfg.data[asbd_pkg::REG_W-1:0];
				asbd_pkg::CFG_RATIO_NUM:    regs_q.ratio_numerator <= cfg.data;
				default: ;
			endcase
		end
	end

	// Handshake and commit conditions.
	assign in_ch.ready = (state_q == ST_IDLE);
	assign slot_free   = !out_valid_q || out_ch.ready;
	assign div_start   = (state_q == ST_PREP) && need_div;
	assign commit      = slot_free &&
		(((state_q == ST_PREP) && !need_div) || (state_q == ST_HOLD));

	// Control sequencer, captured item and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			kind_q      <= asbd_pkg::KIND_TICK;
			key_q       <= 1'b0;
			sample_q    <= '0;
			out_q       <= '0;
		end else begin
			if (commit) begin
				out_valid_q <= 1'b1;
				out_q       <= result;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_ch.valid) begin
						kind_q   <= asbd_pkg::kind_t'(in_ch.kind);
						key_q    <= in_ch.key_request;
						sample_q <= SAMPLE_WIDTH'(in_ch.adc_sample);
						state_q  <= ST_PREP;
					end
				end
				ST_PREP: begin
					if (need_div) begin
						state_q <= ST_DIV;
					end else if (commit) begin
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_HOLD;
					end
				end
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_HOLD;
					end
				end
				default: begin
					if (commit) begin
						state_q <= ST_IDLE;
					end
				end
			endcase
		end
	end

	asbd_sched #(
		.COUNT_WIDTH (COUNT_WIDTH),
		.SAMPLE_WIDTH(SAMPLE_WIDTH)
	) u_sched (
		.clk        (clk),
		.arst_n     (arst_n),
		.commit     (commit),
		.kind       (kind_q),
		.key_request(key_q),
		.adc_sample (sample_q),
		.regs       (regs_q),
		.quotient   (quotient),
		.need_div   (need_div),
		.result     (result)
	);

	asbd_div #(
		.SAMPLE_WIDTH(SAMPLE_WIDTH)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(regs_q.ratio_numerator),
		.divisor (sample_q),
		.done    (div_done),
		.quotient(quotient)
	);

	// Output channel.
	assign out_ch.valid         = out_valid_q;
	assign out_ch.phase         = out_q.phase;
	assign out_ch.adc_open      = out_q.adc_open;
	assign out_ch.adc_close     = out_q.adc_close;
	assign out_ch.collect_flag  = out_q.collect_flag;
	assign out_ch.battery_level = out_q.battery_level;
	assign out_ch.level_valid   = out_q.level_valid;
	assign out_ch.divide_error  = out_q.divide_error;
	assign out_ch.fast_mode     = out_q.fast_mode;

	// A new level only ever comes with the move into the finish phase.
	a_level_finish: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.level_valid) |-> (out_q.phase == asbd_pkg::PH_FINISH))
		else $error("level update outside the finish phase");

	// An error is only flagged together with a level update.
	a_err_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.divide_error) |-> out_q.level_valid)
		else $error("divide error without level update");

	// Opening the converter enters collect with the flag raised.
	a_open_collect: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.adc_open) |->
		((out_q.phase == asbd_pkg::PH_COLLECT) && out_q.collect_flag))
		else $error("open pulse without entering collect");

	// A divider start leads into the wait state with no commit in between.
	a_div_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |=> ((state_q == ST_DIV) && !commit))
		else $error("divider started but sequencer did not wait");

	// The divider finishes only while the sequencer waits for it.
	a_done_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == ST_DIV))
		else $error("divider done outside the wait state");
endmodule

@@ tb/sv/asbd_reading_checker.sv @@
// Checker that predicts and compares every result of the battery measurement scheduler.
`timescale 1ns / 1ps

module asbd_reading_checker (
	input  logic  clk,
	input  logic  arst_n,
	asbd_in_if    in_ch,
	asbd_out_if   out_ch,
	asbd_cfg_if   cfg,
	output int    mismatches,
	output int    pending,
	output int    results_seen,
	output int    levels_seen,
	output int    zero_levels
);
	localparam int MAX_REPORTS = 30;
	localparam int CMP_W       = asbd_pkg::REG_W + 1;

	// Shadow copy of the configuration registers.
	logic [asbd_pkg::REG_W-1:0]   slow_period;
	logic [asbd_pkg::REG_W-1:0]   fast_period;
	logic [asbd_pkg::REG_W-1:0]   fast_window;
	logic [asbd_pkg::REG_W-1:0]   startup_lead;
	logic [asbd_pkg::LEVEL_W-1:0] ratio_num;

	// Shadow copy of the schedule and sequencer state.
	asbd_pkg::phase_t             phase_q;
	logic [asbd_pkg::REG_W-1:0]   slow_cnt;
	logic [asbd_pkg::REG_W-1:0]   window_cnt;
	logic [asbd_pkg::REG_W-1:0]   fast_cnt;
	logic                         fast_on;
	logic                         collecting;
	logic [asbd_pkg::LEVEL_W-1:0] level_q;

	// Expected readings, oldest first.
	asbd_pkg::result_t readings_q[$];

	task automatic report_mismatch(input string msg);
		if (mismatches < MAX_REPORTS)
			$display("[%0t] mismatch: %s", $realtime, msg);
		mismatches++;
	endtask

	task automatic check_field(input string name, input logic [asbd_pkg::LEVEL_W-1:0] got,
			input logic [asbd_pkg::LEVEL_W-1:0] want);
		if (got !== want)
			report_mismatch($sformatf("result %0d field %s got %0h expected %0h",
				results_seen, name, got, want));
	endtask

	// One idle tick of the measurement schedule; counters compare in 17 bits so they never wrap.
	function automatic void advance_schedule();
		logic [CMP_W-1:0] nxt;
		if (fast_on) begin
			nxt = {1'b0, window_cnt} + CMP_W'(1);
			if (nxt <= {1'b0, fast_window}) begin
				window_cnt = nxt[asbd_pkg::REG_W-1:0];
				nxt = {1'b0, fast_cnt} + CMP_W'(1);
				if (nxt >= {1'b0, fast_period}) begin
					phase_q  = asbd_pkg::PH_READY;
					fast_cnt = '0;
				end else begin
					fast_cnt = nxt[asbd_pkg::REG_W-1:0];
				end
			end else begin
				// The fast window has run out: back to slow mode.
				fast_on    = 1'b0;
				window_cnt = '0;
			end
		end else begin
			nxt = {1'b0, slow_cnt} + CMP_W'(1);
			if (nxt >= {1'b0, slow_period}) begin
				phase_q  = asbd_pkg::PH_READY;
				slow_cnt = '0;
			end else begin
				slow_cnt = nxt[asbd_pkg::REG_W-1:0];
			end
		end
	endfunction

	// Applies one input item to the shadow state and returns the reading it produces.
	function automatic asbd_pkg::result_t predict_reading(input asbd_pkg::kind_t kind,
			input logic key, input logic [11:0] sample);
		asbd_pkg::result_t r;
		r = '0;
		if (key)
			fast_on = 1'b1;
		case (kind)
			asbd_pkg::KIND_TICK: begin
				case (phase_q)
					asbd_pkg::PH_IDLE: advance_schedule();
					asbd_pkg::PH_READY: begin
						r.adc_open = 1'b1;
						collecting = 1'b1;
						phase_q    = asbd_pkg::PH_COLLECT;
					end
					asbd_pkg::PH_COLLECT: begin
						// A zero sample saturates the level to the numerator.
						if (sample == '0) begin
							level_q        = ratio_num;
							r.divide_error = 1'b1;
						end else begin
							level_q = ratio_num / asbd_pkg::LEVEL_W'(sample);
						end
						r.level_valid = 1'b1;
						collecting    = 1'b0;
						phase_q       = asbd_pkg::PH_FINISH;
					end
					default: begin
						r.adc_close = 1'b1;
						phase_q     = asbd_pkg::PH_IDLE;
					end
				endcase
			end
			asbd_pkg::KIND_TRIGGER: phase_q = asbd_pkg::PH_READY;
			asbd_pkg::KIND_TRESET: begin
				slow_cnt   = '0;
				window_cnt = '0;
				fast_cnt   = (fast_period == '0) ? '0 : fast_period - asbd_pkg::REG_W'(1);
			end
			default: begin
				slow_cnt = (startup_lead >= slow_period) ? '0 : slow_period - startup_lead;
			end
		endcase
		r.phase         = phase_q;
		r.collect_flag  = collecting;
		r.battery_level = level_q;
		r.fast_mode     = fast_on;
		return r;
	endfunction

	// Follow configuration writes, predict on input transfers, compare on result transfers.
	always @(posedge clk or negedge arst_n) begin
		asbd_pkg::result_t want;
		if (!arst_n) begin
			slow_period  = asbd_pkg::SLOW_PERIOD_RST;
			fast_period  = asbd_pkg::FAST_PERIOD_RST;
			fast_window  = asbd_pkg::FAST_WINDOW_RST;
			startup_lead = asbd_pkg::STARTUP_LEAD_RST;
			ratio_num    = asbd_pkg::RATIO_NUM_RST;
			phase_q      = asbd_pkg::PH_IDLE;
			slow_cnt     = '0;
			window_cnt   = '0;
			fast_cnt     = '0;
			fast_on      = 1'b0;
			collecting   = 1'b0;
			level_q      = '0;
			readings_q.delete();
			mismatches   = 0;
			pending      = 0;
			results_seen = 0;
			levels_seen  = 0;
			zero_levels  = 0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					asbd_pkg::CFG_SLOW_PERIOD:  slow_period  = cfg.data[asbd_pkg::REG_W-1:0];
					asbd_pkg::CFG_FAST_PERIOD:  fast_period  = cfg.data[asbd_pkg::REG_W-1:0];
					asbd_pkg::CFG_FAST_WINDOW:  fast_window  = cfg.data[asbd_pkg::REG_W-1:0];
					asbd_pkg::CFG_STARTUP_LEAD: startup_lead = cfg.data[asbd_pkg::REG_W-1:0];
					asbd_pkg::CFG_RATIO_NUM:    ratio_num    = cfg.data[asbd_pkg::LEVEL_W-1:0];
					default: ;
				endcase
			end
			if (in_ch.valid && in_ch.ready)
				readings_q.push_back(predict_reading(asbd_pkg::kind_t'(in_ch.kind),
					in_ch.key_request, in_ch.adc_sample));
			if (out_ch.valid && out_ch.ready) begin
				if (readings_q.size() == 0) begin
					report_mismatch($sformatf("result with no reading expected, phase %0d",
						out_ch.phase));
				end else begin
					want = readings_q.pop_front();
					check_field("phase", asbd_pkg::LEVEL_W'(out_ch.phase),
						asbd_pkg::LEVEL_W'(want.phase));
					check_field("adc_open", asbd_pkg::LEVEL_W'(out_ch.adc_open),
						asbd_pkg::LEVEL_W'(want.adc_open));
					check_field("adc_close", asbd_pkg::LEVEL_W'(out_ch.adc_close),
						asbd_pkg::LEVEL_W'(want.adc_close));
					check_field("collect_flag", asbd_pkg::LEVEL_W'(out_ch.collect_flag),
						asbd_pkg::LEVEL_W'(want.collect_flag));
					check_field("battery_level", out_ch.battery_level, want.battery_level);
					check_field("level_valid", asbd_pkg::LEVEL_W'(out_ch.level_valid),
						asbd_pkg::LEVEL_W'(want.level_valid));
					check_field("divide_error", asbd_pkg::LEVEL_W'(out_ch.divide_error),
						asbd_pkg::LEVEL_W'(want.divide_error));
					check_field("fast_mode", asbd_pkg::LEVEL_W'(out_ch.fast_mode),
						asbd_pkg::LEVEL_W'(want.fast_mode));
					if (want.level_valid)
						levels_seen++;
					if (want.divide_error)
						zero_levels++;
				end
				results_seen++;
			end
			pending = readings_q.size();
		end
	end

endmodule

@@ tb/sv/adc_sample_scheduler_battery_divider_top_test.sv @@
// Stimulus and verdict for the battery measurement scheduler.
`timescale 1ns / 1ps

module adc_sample_scheduler_battery_divider_top_test;
	localparam int RANDOM_SETS   = 10;
	localparam int ITEMS_PER_SET = 165;
	localparam int PAD_W         = asbd_pkg::CFG_DATA_W - asbd_pkg::REG_W;
	localparam logic [asbd_pkg::CFG_INDEX_W-1:0] CFG_NO_REG = 3'd7;
	localparam logic [asbd_pkg::REG_W-1:0]       REG_MAX    = 16'hFFFF;
	localparam logic [asbd_pkg::LEVEL_W-1:0]     LEVEL_MAX  = 23'h7FFFFF;

	logic clk = 1'b0;
	logic arst_n;

	int sender_idle_pct;
	int receiver_stall_pct;
	int items_sent;
	int mismatches;
	int pending;
	int results_seen;
	int levels_seen;
	int zero_levels;

	asbd_in_if #(.SAMPLE_WIDTH(12)) in_ch ();
	asbd_out_if out_ch ();
	asbd_cfg_if cfg ();

	adc_sample_scheduler_battery_divider_top i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch),
		.cfg    (cfg)
	);

	asbd_reading_checker i_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_ch        (in_ch),
		.out_ch       (out_ch),
		.cfg          (cfg),
		.mismatches   (mismatches),
		.pending      (pending),
		.results_seen (results_seen),
		.levels_seen  (levels_seen),
		.zero_levels  (zero_levels)
	);

	// 8 ns clock.
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Result side: random back-pressure at the current stall rate.
	initial begin
		out_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			out_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);
		end
	end

	// Hard stop in case the block hangs.
	initial begin
		#5000000;
		$display("adc_sample_scheduler_battery_divider_top_test NOT OK");
		$finish;
	end

	// Presents one item after a random gap and holds it until the transfer.
	task automatic send_item(input asbd_pkg::kind_t kind, input logic key,
			input logic [11:0] sample);
		@(negedge clk);
		while ($urandom_range(99) < sender_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(negedge clk);
		end
		in_ch.valid       <= 1'b1;
		in_ch.kind        <= kind;
		in_ch.key_request <= key;
		in_ch.adc_sample  <= sample;
		do @(posedge clk); while (!in_ch.ready);
		items_sent++;
	endtask

	task automatic write_reg(input logic [asbd_pkg::CFG_INDEX_W-1:0] idx,
			input logic [asbd_pkg::CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data  <= val;
		do @(posedge clk); while (!cfg.ready);
		@(negedge clk);
		cfg.valid <= 1'b0;
	endtask

	// Stops the input and waits until every reading has come back.
	task automatic drain();
		@(negedge clk);
		in_ch.valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// Writes all five registers; with noisy set, the unused upper data bits are random.
	task automatic load_settings(input logic [asbd_pkg::REG_W-1:0] slow,
			input logic [asbd_pkg::REG_W-1:0] fast, input logic [asbd_pkg::REG_W-1:0] window,
			input logic [asbd_pkg::REG_W-1:0] lead, input logic [asbd_pkg::LEVEL_W-1:0] num,
			input logic noisy);
		logic [PAD_W-1:0] pad;
		pad = noisy ? PAD_W'($urandom) : '0;
		write_reg(asbd_pkg::CFG_SLOW_PERIOD, {pad, slow});
		write_reg(asbd_pkg::CFG_FAST_PERIOD, {pad, fast});
		write_reg(asbd_pkg::CFG_FAST_WINDOW, {pad, window});
		write_reg(asbd_pkg::CFG_STARTUP_LEAD, {pad, lead});
		write_reg(asbd_pkg::CFG_RATIO_NUM, num);
	endtask

	// Mostly ticks, which drive the sequencer; the rest are triggers, timer resets and inits.
	function automatic asbd_pkg::kind_t pick_kind();
		int r;
		r = $urandom_range(99);
		if (r < 72)
			return asbd_pkg::KIND_TICK;
		else if (r < 80)
			return asbd_pkg::KIND_TRIGGER;
		else if (r < 90)
			return asbd_pkg::KIND_TRESET;
		return asbd_pkg::KIND_INIT;
	endfunction

	// Reference counts with zero, tiny values and full scale over-represented.
	function automatic logic [11:0] pick_sample();
		case ($urandom_range(9))
			0:       return '0;
			1:       return 12'($urandom_range(1, 15));
			2:       return 12'hFFF;
			default: return 12'($urandom);
		endcase
	endfunction

	initial begin
		int mode;
		in_ch.valid        = 1'b0;
		in_ch.kind         = asbd_pkg::KIND_TICK;
		in_ch.key_request  = 1'b0;
		in_ch.adc_sample   = '0;
		cfg.valid          = 1'b0;
		cfg.index          = asbd_pkg::CFG_SLOW_PERIOD;
		cfg.data           = '0;
		sender_idle_pct    = 0;
		receiver_stall_pct = 0;
		items_sent         = 0;
		arst_n             = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed part with the reset configuration.
		send_item(asbd_pkg::KIND_TICK, 1'b0, 12'h000);
		send_item(asbd_pkg::KIND_INIT, 1'b0, 12'h000);
		// Zero sample saturates and flags an error.
		send_item(asbd_pkg::KIND_TRIGGER, 1'b0, 12'h000);
		send_item(asbd_pkg::KIND_TICK, 1'b0, 12'h000);
		send_item(asbd_pkg::KIND_TICK, 1'b0, 12'h000);
		send_item(asbd_pkg::KIND_TICK, 1'b0, 12'h000);
		// Full scale and a sample of one.
		send_item(asbd_pkg::KIND_TRIGGER, 1'b0, 12'hFFF);
		send_item(asbd_pkg::KIND_TICK, 1'b0, 12'hFFF);
		send_item(asbd_pkg::KIND_TICK, 1'b0, 12'hFFF);
		send_item(asbd_pkg::KIND_TICK, 1'b0, 12'hFFF);
		send_item(asbd_pkg::KIND_TRIGGER, 1'b0, 12'h001);
		send_item(asbd_pkg::KIND_TICK, 1'b0, 12'h001);
		send_item(asbd_pkg::KIND_TICK, 1'b0, 12'h001);
		send_item(asbd_pkg::KIND_TICK, 1'b0, 12'h001);
		// Key request, then a timer reset that makes the next fast tick fire.
		send_item(asbd_pkg::KIND_TICK, 1'b1, 12'h000);
		send_item(asbd_pkg::KIND_TRESET, 1'b0, 12'h000);
		send_item(asbd_pkg::KIND_TICK, 1'b0, 12'h000);
		// Triggers in the ready, collect and finish phases.
		send_item(asbd_pkg::KIND_TRIGGER, 1'b0, 12'h000);
		send_item(asbd_pkg::KIND_TICK, 1'b0, 12'h000);
		send_item(asbd_pkg::KIND_TRIGGER, 1'b0, 12'h000);
		send_item(asbd_pkg::KIND_TICK, 1'b0, 12'h000);
		send_item(asbd_pkg::KIND_TICK, 1'b0, 12'h800);
		send_item(asbd_pkg::KIND_TRIGGER, 1'b0, 12'h000);
		send_item(asbd_pkg::KIND_INIT, 1'b1, 12'h555);
		send_item(asbd_pkg::KIND_TICK, 1'b0, 12'hAAA);
		drain();

		// Random part: one configuration set and one idling pattern per round.
		for (int set = 0; set < RANDOM_SETS; set++) begin
			case (set)
				0: load_settings(16'd1, 16'd1, 16'd1, '0, LEVEL_MAX, 1'b0);
				1: load_settings(REG_MAX, REG_MAX, REG_MAX, REG_MAX, 23'd1, 1'b1);
				// Zero periods behave like a period of one.
				2: load_settings('0, '0, '0, '0, '0, 1'b0);
				9: load_settings(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
					23'($urandom), 1'b1);
				default: begin
					load_settings(16'($urandom_range(1, 12)), 16'($urandom_range(1, 6)),
						16'($urandom_range(1, 40)), 16'($urandom_range(0, 15)),
						23'($urandom), 1'b1);
				end
			endcase
			// A write to an index with no register behind it must change nothing.
			if (set == 3)
				write_reg(CFG_NO_REG, 23'($urandom));

			mode = set % 4;
			sender_idle_pct    = (mode == 1) ? 84 : (mode == 3) ? 21 : 0;
			receiver_stall_pct = (mode == 2) ? 84 : (mode == 3) ? 21 : 0;
			for (int n = 0; n < ITEMS_PER_SET; n++)
				send_item(pick_kind(), ($urandom_range(99) < 6), pick_sample());
			drain();
		end

		repeat (40) @(negedge clk);
		$display("Sent %0d items over %0d configuration sets plus the reset set.",
			items_sent, RANDOM_SETS);
		$display("Checked %0d results, %0d level conversions, %0d of them on a zero sample.",
			results_seen, levels_seen, zero_levels);
		if (mismatches == 0 && pending == 0)
			$display("adc_sample_scheduler_battery_divider_top_test OK");
		else
			$display("adc_sample_scheduler_battery_divider_top_test NOT OK");
		$finish;
	end

endmodule
